>>> rtl/core/mtfc_pkg.sv
// Shared types and constants for the move-to-front codec.
// No dependencies; imported by mtfc_cell and move_to_front_codec_top.
`timescale 1ns / 1ps
`default_nettype none

package mtfc_pkg;

  // Symbol and position width, fixed by the byte alphabet
  localparam int unsigned SYM_W = 8;

  // Default number of symbols in the recency list
  localparam int unsigned ALPHABET_SIZE_DEF = 256;

  // Mode codes
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Token handed from one cell to the next.
  // Before the hit, data carries the entry displaced by the shift;
  // after the hit, it carries the answer down to the end of the chain.
  typedef struct packed {
    logic             tok;
    logic             done;
    logic [SYM_W-1:0] data;
  } link_t;

endpackage

`default_nettype wire

>>> rtl/core/mtfc_cell.sv
// One cell of the recency chain: holds one list entry and forwards the token.
// Depends on mtfc_pkg for link_t, SYM_W and the mode codes.
`timescale 1ns / 1ps
`default_nettype none

module mtfc_cell #(
  parameter int unsigned INDEX = 0
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        restore_i,
  input  wire                        mode_i,
  input  wire [mtfc_pkg::SYM_W-1:0]  target_i,
  input  wire                        wb_i,
  input  wire [mtfc_pkg::SYM_W-1:0]  wb_data_i,
  input  mtfc_pkg::link_t            link_i,
  output mtfc_pkg::link_t            link_o
);
  import mtfc_pkg::*;

  localparam logic [SYM_W-1:0] IDX = SYM_W'(INDEX);

  logic [SYM_W-1:0] entry_q, entry_d;
  link_t            link_q, link_d;
  logic             live;
  logic             hit;

  // Match on symbol when encoding, on position when decoding
  assign live = link_i.tok & ~link_i.done;
  assign hit  = live & ((mode_i == MODE_DECODE) ? (IDX == target_i) : (entry_q == target_i));

  // Update the entry: restore identity, take the write-back, or shift in the carry
  always_comb begin
    entry_d = entry_q;
    if (restore_i) begin
      entry_d = IDX;
    end else if (wb_i) begin
      entry_d = wb_data_i;
    end else if (live) begin
      entry_d = link_i.data;
    end
  end

  // Forward the token; on a hit replace the carry with the answer
  always_comb begin
    link_d.tok  = link_i.tok;
    link_d.done = link_i.done | hit;
    if (link_i.done) begin
      link_d.data = link_i.data;
    end else if (hit) begin
      link_d.data = (mode_i == MODE_DECODE) ? entry_q : IDX;
    end else begin
      link_d.data = entry_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q     <= IDX;
      link_q.tok  <= 1'b0;
      link_q.done <= 1'b0;
      link_q.data <= '0;
    end else begin
      entry_q     <= entry_d;
      link_q.tok  <= link_d.tok;
      link_q.done <= link_d.done;
      link_q.data <= link_d.data;
    end
  end

  assign link_o = link_q;

endmodule

`default_nettype wire

>>> rtl/core/move_to_front_codec_top.sv
// Top level of the move-to-front codec: controller plus a chain of mtfc_cell.
// Depends on mtfc_pkg and mtfc_cell.
//
//  Channel | Handshake              | Payload
//  --------+------------------------+--------------------------------------
//  input   | in_valid_i / in_ready_o | mode_i, value_i, start_of_stream_i
//  output  | out_valid_o / out_ready_i | result_o
//
// After acceptance a token walks the chain of cells one cell per cycle,
// shifting entries back until the hit and carrying the answer to the end of
// the chain, where the result is registered. Encoding a symbol outside the
// alphabet answers in the cycle after acceptance.
// One transaction is in work at a time; input stalls until the result is taken.
// Reset loads identity order into every cell at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module move_to_front_codec_top #(
  parameter int unsigned ALPHABET_SIZE = mtfc_pkg::ALPHABET_SIZE_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire                        mode_i,
  input  wire [mtfc_pkg::SYM_W-1:0]  value_i,
  input  wire                        start_of_stream_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output logic [mtfc_pkg::SYM_W-1:0] result_o
);
  import mtfc_pkg::*;

  localparam int unsigned N = ALPHABET_SIZE;
  localparam logic [SYM_W:0]   N_EXT     = (SYM_W + 1)'(N);
  localparam logic [SYM_W-1:0] LAST_POS  = SYM_W'(N - 1);
  localparam logic [SYM_W-1:0] MISS_CODE = SYM_W'(N % 256);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic             state_q, state_d;
  logic             mode_q;
  logic [SYM_W-1:0] target_q;
  logic             out_valid_q, out_valid_d;
  logic [SYM_W-1:0] result_q, result_d;
  link_t            launch_q, launch_d;
  link_t            link_w [N];
  logic [N-1:0]     tok_vec;
  logic             in_acc;
  logic             out_acc;
  logic             restore;
  logic             out_of_range;
  logic             exit_tok;

  assign in_ready_o   = (state_q == ST_IDLE) & ~out_valid_q;
  assign in_acc       = in_valid_i & in_ready_o;
  assign out_acc      = out_valid_q & out_ready_i;
  assign restore      = in_acc & start_of_stream_i;
  assign out_of_range = ({1'b0, value_i} >= N_EXT);
  assign exit_tok     = link_w[N-1].tok;

  // Sequence one transaction: launch, walk, capture the answer at the chain end (out-of-range encodes skip the walk)
  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q & ~out_acc;
    result_d      = result_q;
    launch_d.tok  = 1'b0;
    launch_d.done = 1'b0;
    launch_d.data = value_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if ((mode_i == MODE_ENCODE) && out_of_range) begin
            result_d    = MISS_CODE;
            out_valid_d = 1'b1;
          end else begin
            launch_d.tok = 1'b1;
            state_d      = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (exit_tok) begin
          result_d    = link_w[N-1].data;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      launch_q.tok  <= 1'b0;
      launch_q.done <= 1'b0;
      launch_q.data <= '0;
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      launch_q.tok  <= launch_d.tok;
      launch_q.done <= launch_d.done;
      launch_q.data <= launch_d.data;
    end
  end

  // Hold the transaction payload; saturate decode positions to the last entry
  always_ff @(posedge clk_i) begin
    result_q      <= result_d;
    if (in_acc) begin
      mode_q   <= mode_i;
      target_q <= ((mode_i == MODE_DECODE) && out_of_range) ? LAST_POS : value_i;
    end
  end

  // Build the chain; cell 0 takes the decoded symbol back at the end of a walk
  for (genvar k = 0; k < N; k++) begin : g_cell
    if (k == 0) begin : g_head
      mtfc_cell #(
        .INDEX (k)
      ) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .restore_i (restore),
        .mode_i    (mode_q),
        .target_i  (target_q),
        .wb_i      (exit_tok & (mode_q == MODE_DECODE)),
        .wb_data_i (link_w[N-1].data),
        .link_i    (launch_q),
        .link_o    (link_w[k])
      );
    end else begin : g_body
      mtfc_cell #(
        .INDEX (k)
      ) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .restore_i (restore),
        .mode_i    (mode_q),
        .target_i  (target_q),
        .wb_i      (1'b0),
        .wb_data_i (link_w[N-1].data),
        .link_i    (link_w[k-1]),
        .link_o    (link_w[k])
      );
    end
    assign tok_vec[k] = link_w[k].tok;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

`ifndef SYNTH
  // At most one token travels the chain
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({tok_vec, launch_q.tok}))
    else $error("more than one token in the chain");

  // Input is taken only with the chain empty
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (tok_vec == '0) && !launch_q.tok)
    else $error("input ready while a walk is in progress");

  // Every walk finds its entry before leaving the chain
  a_exit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exit_tok |-> link_w[N-1].done)
    else $error("token left the chain without a hit");
`endif

endmodule

`default_nettype wire
